// File: design/mspm_pkg.sv
package mspm_pkg;

   // fixed field widths of the two channels
   localparam int CMD_W       = 2;
   localparam int SEL_W       = 4;
   localparam int PUSH_W      = 16;
   localparam int POS_W       = 6;
   localparam int STATUS_W    = 2;
   localparam int DEPTH_OUT_W = 7;
   localparam int DATA_OUT_W  = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH = 2'd0,
      CMD_POP  = 2'd1,
      CMD_MOVE = 2'd2,
      CMD_READ = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_SELF_MOVE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRC,
      S_DST,
      S_COPY,
      S_CLR,
      S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic src_exec;
      logic dst_exec;
      logic copy_step;
      logic clear_src;
      logic respond;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_move;
      logic move_go;
      logic move_clr;
      logic copy_done;
      logic out_free;
   } dp_stat_type;

endpackage

// File: design/mspm_req_if.sv
interface mspm_req_if;
   import mspm_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [SEL_W-1:0]    stack_sel;
   logic [SEL_W-1:0]    dest_stack;
   logic [PUSH_W-1:0]   push_value;
   logic [POS_W-1:0]    read_pos;

   modport source (
      output valid, command, stack_sel, dest_stack, push_value, read_pos,
      input  ready
   );

   modport sink (
      input  valid, command, stack_sel, dest_stack, push_value, read_pos,
      output ready
   );

endinterface

// File: design/mspm_rsp_if.sv
interface mspm_rsp_if;
   import mspm_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [DEPTH_OUT_W-1:0] depth_now;
   logic [DATA_OUT_W-1:0]  read_data;

   modport source (
      output valid, status, depth_now, read_data,
      input  ready
   );

   modport sink (
      input  valid, status, depth_now, read_data,
      output ready
   );

endinterface

// File: design/mspm_ctrl.sv
module mspm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mspm_pkg::dp_stat_type  dp_stat,
   output mspm_pkg::ctrl_cmd_type ctrl_cmd
);
   import mspm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SRC;
         end
         S_SRC: begin
            state_in = dp_stat.is_move ? S_DST : S_DONE;
         end
         S_DST: begin
            priority if (dp_stat.move_go) state_in = S_COPY;
            else if (dp_stat.move_clr)    state_in = S_CLR;
            else                          state_in = S_DONE;
         end
         S_COPY: begin
            if (dp_stat.copy_done) state_in = S_CLR;
         end
         S_CLR: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (dp_stat.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ctrl_cmd  = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready        = 1'b1;
            ctrl_cmd.capture = req_valid;
         end
         S_SRC:  ctrl_cmd.src_exec  = 1'b1;
         S_DST:  ctrl_cmd.dst_exec  = 1'b1;
         S_COPY: ctrl_cmd.copy_step = 1'b1;
         S_CLR:  ctrl_cmd.clear_src = 1'b1;
         S_DONE: ctrl_cmd.respond   = dp_stat.out_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: design/mspm_datapath.sv
module mspm_datapath #(
   parameter int NUM_STACKS  = 16,
   parameter int STACK_DEPTH = 64,
   parameter int VALUE_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [mspm_pkg::CMD_W-1:0]         req_command,
   input  logic [mspm_pkg::SEL_W-1:0]         req_stack_sel,
   input  logic [mspm_pkg::SEL_W-1:0]         req_dest_stack,
   input  logic [mspm_pkg::PUSH_W-1:0]        req_push_value,
   input  logic [mspm_pkg::POS_W-1:0]         req_read_pos,
   input  mspm_pkg::ctrl_cmd_type             ctrl_cmd,
   output mspm_pkg::dp_stat_type              dp_stat,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mspm_pkg::STATUS_W-1:0]      rsp_status,
   output logic [mspm_pkg::DEPTH_OUT_W-1:0]   rsp_depth_now,
   output logic [mspm_pkg::DATA_OUT_W-1:0]    rsp_read_data
);
   import mspm_pkg::*;

   localparam int SW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int CW    = $clog2(STACK_DEPTH + 1);
   localparam int CW1   = CW + 1;
   localparam int TOTAL = NUM_STACKS * STACK_DEPTH;
   localparam int AW    = $clog2(TOTAL);
   localparam int PCW   = (CW > POS_W) ? CW : POS_W;
   localparam int VB    = VALUE_BITS;
   localparam int SEL_N = 1 << SEL_W;

   localparam logic [CW-1:0]  DEPTH_C = CW'(STACK_DEPTH);
   localparam logic [CW1-1:0] DEPTH_S = CW1'(STACK_DEPTH);
   localparam logic [AW-1:0]  DEPTH_A = AW'(STACK_DEPTH);

   // captured command
   cmd_type          cmd_ff,    cmd_in;
   logic [SW-1:0]    s_ff,      s_in;
   logic [SW-1:0]    d_ff,      d_in;
   logic [VB-1:0]    val_ff,    val_in;
   logic [POS_W-1:0] pos_ff,    pos_in;
   logic [AW-1:0]    base_s_ff, base_s_in;
   logic [AW-1:0]    base_d_ff, base_d_in;

   // execution state
   logic [CW-1:0]    cs_ff,      cs_in;
   logic [AW-1:0]    wr_base_ff, wr_base_in;
   logic [CW-1:0]    rd_idx_ff,  rd_idx_in;
   logic [CW-1:0]    wr_idx_ff,  wr_idx_in;
   logic             wr_pend_ff, wr_pend_in;
   status_type       res_status_ff, res_status_in;
   logic [CW-1:0]    res_depth_ff,  res_depth_in;
   logic             res_mem_ff,    res_mem_in;

   // output register
   logic                   rsp_valid_ff,  rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [DEPTH_OUT_W-1:0] rsp_depth_ff,  rsp_depth_in;
   logic [DATA_OUT_W-1:0]  rsp_data_ff,   rsp_data_in;

   // count store with per-entry valid bits
   logic [CW-1:0]         cnt_mem [NUM_STACKS];
   logic [NUM_STACKS-1:0] cnt_valid_ff, cnt_valid_in;
   logic [CW-1:0]         cnt_q_ff;
   logic                  cnt_rd_en;
   logic [SW-1:0]         cnt_rd_addr;
   logic                  cnt_wr_en;
   logic [SW-1:0]         cnt_wr_addr;
   logic [CW-1:0]         cnt_wr_data;

   // element store
   logic [VB-1:0] elem_mem [TOTAL];
   logic [VB-1:0] elem_rd_ff;
   logic          elem_rd_en;
   logic [AW-1:0] elem_rd_addr;
   logic          elem_wr_en;
   logic [AW-1:0] elem_wr_addr;
   logic [VB-1:0] elem_wr_data;

   // stack number modulo NUM_STACKS for every select code
   logic [SW-1:0] sel_map [SEL_N];

   logic [SW-1:0]  sel_red;
   logic [SW-1:0]  dst_red;
   logic [CW-1:0]  cnt_inc;
   logic [CW-1:0]  cnt_dec;
   logic [CW-1:0]  cs_dec;
   logic [CW1-1:0] move_sum;
   logic           push_ok;
   logic           pop_ok;
   logic           read_ok;
   logic           self_move;
   logic           move_ovf;
   logic           move_ok;
   logic           copy_rd_go;
   logic           out_free;

   for (genvar g = 0; g < SEL_N; g++) begin : g_sel_map
      assign sel_map[g] = SW'(g % NUM_STACKS);
   end

   assign sel_red    = sel_map[req_stack_sel];
   assign dst_red    = sel_map[req_dest_stack];
   assign cnt_inc    = cnt_q_ff + CW'(1);
   assign cnt_dec    = cnt_q_ff - CW'(1);
   assign cs_dec     = cs_ff - CW'(1);
   assign push_ok    = cnt_q_ff < DEPTH_C;
   assign pop_ok     = cnt_q_ff != '0;
   assign read_ok    = PCW'(pos_ff) < PCW'(cnt_q_ff);
   // in the destination step cnt_q_ff holds the destination count
   assign move_sum   = CW1'(cs_ff) + CW1'(cnt_q_ff);
   assign self_move  = s_ff == d_ff;
   assign move_ovf   = move_sum > DEPTH_S;
   assign move_ok    = !self_move && !move_ovf;
   assign copy_rd_go = rd_idx_ff != cs_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign dp_stat.is_move   = cmd_ff == CMD_MOVE;
   assign dp_stat.move_go   = move_ok && (cs_ff != '0);
   assign dp_stat.move_clr  = move_ok && (cs_ff == '0);
   assign dp_stat.copy_done = ctrl_cmd.copy_step && wr_pend_ff && (wr_idx_ff == cs_dec);
   assign dp_stat.out_free  = out_free;

   // capture on input transfer
   always_comb begin
      cmd_in    = cmd_ff;
      s_in      = s_ff;
      d_in      = d_ff;
      val_in    = val_ff;
      pos_in    = pos_ff;
      base_s_in = base_s_ff;
      base_d_in = base_d_ff;
      if (ctrl_cmd.capture) begin
         cmd_in    = cmd_type'(req_command);
         s_in      = sel_red;
         d_in      = dst_red;
         val_in    = VB'(req_push_value);
         pos_in    = req_read_pos;
         base_s_in = AW'(sel_red) * DEPTH_A;
         base_d_in = AW'(dst_red) * DEPTH_A;
      end
   end

   // command decisions and copy sequencing
   always_comb begin
      cs_in         = cs_ff;
      wr_base_in    = wr_base_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      wr_pend_in    = wr_pend_ff;
      res_status_in = res_status_ff;
      res_depth_in  = res_depth_ff;
      res_mem_in    = res_mem_ff;

      if (ctrl_cmd.src_exec) begin
         cs_in      = cnt_q_ff;
         res_mem_in = 1'b0;
         unique case (cmd_ff)
            CMD_PUSH: begin
               res_status_in = push_ok ? ST_OK : ST_OVERFLOW;
               res_depth_in  = push_ok ? cnt_inc : cnt_q_ff;
            end
            CMD_POP: begin
               res_status_in = pop_ok ? ST_OK : ST_EMPTY;
               res_depth_in  = pop_ok ? cnt_dec : '0;
               res_mem_in    = pop_ok;
            end
            CMD_MOVE: begin
               res_depth_in = cnt_q_ff;
            end
            CMD_READ: begin
               res_status_in = read_ok ? ST_OK : ST_EMPTY;
               res_depth_in  = cnt_q_ff;
               res_mem_in    = read_ok;
            end
         endcase
      end

      if (ctrl_cmd.dst_exec) begin
         res_mem_in = 1'b0;
         priority if (self_move) begin
            res_status_in = ST_SELF_MOVE;
            res_depth_in  = cs_ff;
         end else if (move_ovf) begin
            res_status_in = ST_OVERFLOW;
            res_depth_in  = cs_ff;
         end else begin
            res_status_in = ST_OK;
            res_depth_in  = '0;
         end
         wr_base_in = base_d_ff + AW'(cnt_q_ff);
         rd_idx_in  = '0;
         wr_idx_in  = '0;
         wr_pend_in = 1'b0;
      end

      // read of element i overlaps the write of element i-1
      if (ctrl_cmd.copy_step) begin
         wr_pend_in = copy_rd_go;
         if (copy_rd_go) rd_idx_in = rd_idx_ff + CW'(1);
         if (wr_pend_ff) wr_idx_in = wr_idx_ff + CW'(1);
      end
   end

   // element store access
   always_comb begin
      elem_rd_en   = 1'b0;
      elem_rd_addr = base_s_ff;
      elem_wr_en   = 1'b0;
      elem_wr_addr = base_s_ff;
      elem_wr_data = val_ff;
      if (ctrl_cmd.src_exec) begin
         unique case (cmd_ff)
            CMD_PUSH: begin
               elem_wr_en   = push_ok;
               elem_wr_addr = base_s_ff + AW'(cnt_q_ff);
            end
            CMD_POP: begin
               elem_rd_en   = pop_ok;
               elem_rd_addr = base_s_ff + AW'(cnt_dec);
            end
            CMD_MOVE: begin
               elem_rd_en = 1'b0;
            end
            CMD_READ: begin
               elem_rd_en   = read_ok;
               elem_rd_addr = base_s_ff + AW'(pos_ff);
            end
         endcase
      end
      if (ctrl_cmd.copy_step) begin
         elem_rd_en   = copy_rd_go;
         elem_rd_addr = base_s_ff + AW'(rd_idx_ff);
         elem_wr_en   = wr_pend_ff;
         elem_wr_addr = wr_base_ff + AW'(wr_idx_ff);
         elem_wr_data = elem_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (elem_wr_en) elem_mem[elem_wr_addr] <= elem_wr_data;
      if (elem_rd_en) elem_rd_ff <= elem_mem[elem_rd_addr];
   end

   // count store access
   always_comb begin
      cnt_rd_en   = 1'b0;
      cnt_rd_addr = s_ff;
      cnt_wr_en   = 1'b0;
      cnt_wr_addr = s_ff;
      cnt_wr_data = '0;
      if (ctrl_cmd.capture) begin
         cnt_rd_en   = 1'b1;
         cnt_rd_addr = sel_red;
      end
      if (ctrl_cmd.src_exec) begin
         unique case (cmd_ff)
            CMD_PUSH: begin
               cnt_wr_en   = push_ok;
               cnt_wr_data = cnt_inc;
            end
            CMD_POP: begin
               cnt_wr_en   = pop_ok;
               cnt_wr_data = cnt_dec;
            end
            CMD_MOVE: begin
               cnt_rd_en   = 1'b1;
               cnt_rd_addr = d_ff;
            end
            CMD_READ: begin
               cnt_wr_en = 1'b0;
            end
         endcase
      end
      if (ctrl_cmd.dst_exec) begin
         cnt_wr_en   = move_ok;
         cnt_wr_addr = d_ff;
         cnt_wr_data = CW'(move_sum);
      end
      if (ctrl_cmd.clear_src) begin
         cnt_wr_en   = 1'b1;
         cnt_wr_addr = s_ff;
         cnt_wr_data = '0;
      end
   end

   always_comb begin
      cnt_valid_in = cnt_valid_ff;
      if (cnt_wr_en) cnt_valid_in[cnt_wr_addr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cnt_wr_en) cnt_mem[cnt_wr_addr] <= cnt_wr_data;
      if (cnt_rd_en) cnt_q_ff <= cnt_valid_ff[cnt_rd_addr] ? cnt_mem[cnt_rd_addr] : '0;
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_data_in   = rsp_data_ff;
      if (ctrl_cmd.respond) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_depth_in  = DEPTH_OUT_W'(res_depth_ff);
         rsp_data_in   = res_mem_ff ? DATA_OUT_W'(elem_rd_ff) : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_valid_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_valid_ff <= cnt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      s_ff          <= s_in;
      d_ff          <= d_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      base_s_ff     <= base_s_in;
      base_d_ff     <= base_d_in;
      cs_ff         <= cs_in;
      wr_base_ff    <= wr_base_in;
      rd_idx_ff     <= rd_idx_in;
      wr_idx_ff     <= wr_idx_in;
      wr_pend_ff    <= wr_pend_in;
      res_status_ff <= res_status_in;
      res_depth_ff  <= res_depth_in;
      res_mem_ff    <= res_mem_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_depth_now = rsp_depth_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

// File: design/multi_stack_push_pop_move_core.sv
// NUM_STACKS stacks of up to STACK_DEPTH values share one element memory; stack s owns
// entries s*STACK_DEPTH to s*STACK_DEPTH+STACK_DEPTH-1. Each command transfer on req_bus
// yields exactly one result transfer on rsp_bus. Push, pop and read do count lookup,
// element access and result load; the load waits while an earlier result is stalled, and
// the next command is taken the cycle after the result is loaded. A move reads both counts,
// copies one element per cycle through the memory's read and write ports, reading
// element i while writing element i-1, then clears the source count. Failed moves skip
// the copy and the clear, moves of an empty source skip the copy. Stack counts carry
// per-entry valid bits cleared by reset, so no clearing pass is needed and the block takes
// commands right after reset. Failed commands (empty pop, read past the count, overflow,
// move onto itself) report a nonzero status and leave all state unchanged.
module multi_stack_push_pop_move_core #(
   parameter int NUM_STACKS  = 16,
   parameter int STACK_DEPTH = 64,
   parameter int VALUE_BITS  = 16
) (
   input logic        clock,
   input logic        reset,
   mspm_req_if.sink   req_bus,
   mspm_rsp_if.source rsp_bus
);
   import mspm_pkg::*;

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   mspm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .dp_stat   (dp_stat),
      .ctrl_cmd  (ctrl_cmd)
   );

   mspm_datapath #(
      .NUM_STACKS  (NUM_STACKS),
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_BITS  (VALUE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_bus.command),
      .req_stack_sel  (req_bus.stack_sel),
      .req_dest_stack (req_bus.dest_stack),
      .req_push_value (req_bus.push_value),
      .req_read_pos   (req_bus.read_pos),
      .ctrl_cmd       (ctrl_cmd),
      .dp_stat        (dp_stat),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_status     (rsp_bus.status),
      .rsp_depth_now  (rsp_bus.depth_now),
      .rsp_read_data  (rsp_bus.read_data)
   );

endmodule

// File: design/mspm_checker.sv
module mspm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [mspm_pkg::STATUS_W-1:0]      rsp_status,
   input logic [mspm_pkg::DEPTH_OUT_W-1:0]   rsp_depth_now,
   input logic [mspm_pkg::DATA_OUT_W-1:0]    rsp_read_data
);
   import mspm_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable({rsp_status, rsp_depth_now, rsp_read_data}))
      else $error("result changed while stalled");

   // failed commands return no data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_read_data == '0)
      else $error("nonzero data on failed command");

   // one command at a time: no transfer in the cycle after a transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command taken while busy");

   // ready to take a command right after reset
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_ready)
      else $error("not ready after reset");

endmodule

bind multi_stack_push_pop_move_core mspm_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_status    (rsp_bus.status),
   .rsp_depth_now (rsp_bus.depth_now),
   .rsp_read_data (rsp_bus.read_data)
);
